FILE: rtl/hvt_pkg.sv
package hvt_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int COORD_W       = 32;
  localparam int PROD_W        = 2 * COORD_W;
  // A row sum of four 64-bit products needs two more bits.
  localparam int SUM_W         = PROD_W + 2;
  // Quotient bits kept; anything at or above 2**QUO_W is an overflow.
  localparam int QUO_W         = COORD_W + 1;
  localparam int DIV_W         = SUM_W + QUO_W + 1;
  localparam int NUM_REGS      = 8;
  localparam int REG_IDX_W     = $clog2(NUM_REGS);
  localparam int CFG_IDX_W     = 4;
  localparam int CFG_DATA_W    = 64;

  localparam int REG_R0_C01 = 0;
  localparam int REG_R0_C23 = 1;
  localparam int REG_R1_C01 = 2;
  localparam int REG_R1_C23 = 3;
  localparam int REG_R2_C01 = 4;
  localparam int REG_R2_C23 = 5;
  localparam int REG_R3_C01 = 6;
  localparam int REG_R3_C23 = 7;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [SUM_W-1:0]   sum_t;

endpackage

FILE: rtl/hvt_in_if.sv
interface hvt_in_if import hvt_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t in_x;
  coord_t in_y;
  coord_t in_z;

  modport source (output valid, output in_x, output in_y, output in_z, input ready);
  modport sink   (input valid, input in_x, input in_y, input in_z, output ready);
endinterface

FILE: rtl/hvt_out_if.sv
interface hvt_out_if import hvt_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t out_x;
  coord_t out_y;
  coord_t out_z;
  logic   w_zero;
  logic   saturated;

  modport source (output valid, output out_x, output out_y, output out_z, output w_zero,
                  output saturated, input ready);
  modport sink   (input valid, input out_x, input out_y, input out_z, input w_zero,
                  input saturated, output ready);
endinterface

FILE: rtl/hvt_cfg_if.sv
interface hvt_cfg_if import hvt_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/hvt_divider.sv
module hvt_divider import hvt_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [DIV_W-1:0] num,
  input  logic [SUM_W-1:0] den,
  output logic [QUO_W-1:0] quo,
  output logic             ovf
);

  logic [DIV_W-1:0] rem_r [QUO_W];
  logic [SUM_W-1:0] den_r [QUO_W];
  logic [QUO_W-1:0] q_r   [QUO_W+1];
  logic             ovf_r [QUO_W+1];

  logic [DIV_W-1:0] dsh_first;
  assign dsh_first = DIV_W'(den) << QUO_W;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= num;
      den_r[0] <= den;
      q_r[0]   <= '0;
      ovf_r[0] <= (num >= dsh_first);
    end
  end

  for (genvar j = 1; j <= QUO_W; j++) begin : g_step
    logic [DIV_W-1:0] dsh;
    logic             ge;

    assign dsh = DIV_W'(den_r[j-1]) << (QUO_W - j);
    assign ge  = rem_r[j-1] >= dsh;

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[j]   <= q_r[j-1] | (ge ? (QUO_W'(1) << (QUO_W - j)) : '0);
        ovf_r[j] <= ovf_r[j-1];
      end
    end

    if (j < QUO_W) begin : g_keep
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[j] <= ge ? (rem_r[j-1] - dsh) : rem_r[j-1];
          den_r[j] <= den_r[j-1];
        end
      end
    end
  end

  assign quo = q_r[QUO_W];
  assign ovf = ovf_r[QUO_W];

endmodule

FILE: rtl/homogeneous_vertex_transform.sv
// Transforms one point (x, y, z, 1) per clock by a 4x4 signed fixed-point matrix and divides
// x', y' and z' by w', giving signed fixed-point results that saturate on overflow and read
// zero when w' is zero. The pipeline has one stage of multipliers, one of row sums, one to
// take magnitudes, one restoring division step per quotient bit plus an overflow check, and
// the output register. A new word enters in every cycle; the whole pipeline holds while the
// output word is not taken. The matrix resets to the identity. The user must write it through
// the configuration channel only while idle; the block itself does not enforce this.
module homogeneous_vertex_transform import hvt_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input logic      clk,
  input logic      rst_n,
  hvt_in_if.sink   in_ch,
  hvt_out_if.source out_ch,
  hvt_cfg_if.sink  cfg_ch
);

  localparam logic [CFG_DATA_W-1:0] ONE = CFG_DATA_W'(1) << FRAC_BITS;

  logic [CFG_DATA_W-1:0] cfg_r [NUM_REGS];
  coord_t                m [4][4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r[REG_R0_C01] <= ONE;
      cfg_r[REG_R0_C23] <= '0;
      cfg_r[REG_R1_C01] <= ONE << COORD_W;
      cfg_r[REG_R1_C23] <= '0;
      cfg_r[REG_R2_C01] <= '0;
      cfg_r[REG_R2_C23] <= ONE;
      cfg_r[REG_R3_C01] <= '0;
      cfg_r[REG_R3_C23] <= ONE << COORD_W;
    end else if (cfg_ch.valid && cfg_ch.ready && cfg_ch.index < CFG_IDX_W'(NUM_REGS)) begin
      cfg_r[cfg_ch.index[REG_IDX_W-1:0]] <= cfg_ch.data;
    end
  end

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int p = 0; p < 2; p++) begin
        for (int h = 0; h < 2; h++) begin
          m[r][2*p+h] = cfg_r[2*r+p][COORD_W*h +: COORD_W];
        end
      end
    end
  end

  logic en;
  logic out_valid_r;
  assign en = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  // Stage 1: products.
  logic                     v1_r;
  logic signed [PROD_W-1:0] prod_r [4][4];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        prod_r[r][0] <= m[r][0] * in_ch.in_x;
        prod_r[r][1] <= m[r][1] * in_ch.in_y;
        prod_r[r][2] <= m[r][2] * in_ch.in_z;
        prod_r[r][3] <= PROD_W'(m[r][3]) <<< FRAC_BITS;
      end
    end
  end

  // Stage 2: row sums.
  logic v2_r;
  sum_t sum_r [4];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        sum_r[r] <= SUM_W'(prod_r[r][0]) + SUM_W'(prod_r[r][1])
                  + SUM_W'(prod_r[r][2]) + SUM_W'(prod_r[r][3]);
      end
    end
  end

  // Stage 3: magnitudes and signs.
  logic             v3_r;
  logic [DIV_W-1:0] num_r [3];
  logic [SUM_W-1:0] den_r;
  logic             neg3_r [3];
  logic             wz3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        num_r[k]  <= DIV_W'(sum_r[k][SUM_W-1] ? -sum_r[k] : sum_r[k]) << FRAC_BITS;
        neg3_r[k] <= sum_r[k][SUM_W-1] ^ sum_r[3][SUM_W-1];
      end
      den_r <= sum_r[3][SUM_W-1] ? -sum_r[3] : sum_r[3];
      wz3_r <= (sum_r[3] == '0);
    end
  end

  logic [QUO_W-1:0] quo [3];
  logic             ovf [3];

  for (genvar k = 0; k < 3; k++) begin : g_lane
    hvt_divider u_div (
      .clk (clk),
      .en  (en),
      .num (num_r[k]),
      .den (den_r),
      .quo (quo[k]),
      .ovf (ovf[k])
    );
  end

  // Side information running alongside the divider stages.
  logic vd_r   [QUO_W+1];
  logic wzd_r  [QUO_W+1];
  logic negd_r [QUO_W+1][3];

  always_ff @(posedge clk) begin
    if (en) begin
      wzd_r[0]  <= wz3_r;
      negd_r[0] <= neg3_r;
      for (int j = 1; j <= QUO_W; j++) begin
        wzd_r[j]  <= wzd_r[j-1];
        negd_r[j] <= negd_r[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
      for (int j = 0; j <= QUO_W; j++) begin
        vd_r[j] <= 1'b0;
      end
    end else if (en) begin
      v1_r    <= in_ch.valid;
      v2_r    <= v1_r;
      v3_r    <= v2_r;
      vd_r[0] <= v3_r;
      for (int j = 1; j <= QUO_W; j++) begin
        vd_r[j] <= vd_r[j-1];
      end
      out_valid_r <= vd_r[QUO_W];
    end
  end

  // Output stage: clamp, restore sign, handle zero w.
  coord_t           res_nxt [3];
  logic             sat_nxt;
  coord_t           res_r [3];
  logic             sat_r;
  logic             wz_r;

  always_comb begin
    logic [QUO_W-1:0] lim;
    logic [QUO_W-1:0] mag;
    logic             s;
    sat_nxt = 1'b0;
    for (int k = 0; k < 3; k++) begin
      lim = negd_r[QUO_W][k] ? (QUO_W'(1) << (COORD_W - 1))
                             : ((QUO_W'(1) << (COORD_W - 1)) - QUO_W'(1));
      s   = ovf[k] || (quo[k] > lim);
      mag = s ? lim : quo[k];
      res_nxt[k] = negd_r[QUO_W][k] ? COORD_W'(-mag) : COORD_W'(mag);
      sat_nxt = sat_nxt | s;
    end
    if (wzd_r[QUO_W]) begin
      for (int k = 0; k < 3; k++) begin
        res_nxt[k] = '0;
      end
      sat_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
      sat_r <= sat_nxt;
      wz_r  <= wzd_r[QUO_W];
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_x     = res_r[0];
  assign out_ch.out_y     = res_r[1];
  assign out_ch.out_z     = res_r[2];
  assign out_ch.w_zero    = wz_r;
  assign out_ch.saturated = sat_r;

  a_wzero_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.w_zero) |-> (!out_ch.saturated && out_ch.out_x == '0
      && out_ch.out_y == '0 && out_ch.out_z == '0))
    else $error("zero w result carries nonzero data");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> v1_r)
    else $error("accepted word lost at first stage");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(res_r[0]) && $stable(wz_r)))
    else $error("stalled result changed");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("output valid after reset");

endmodule

FILE: bench/tb_homogeneous_vertex_transform.sv
module tb_homogeneous_vertex_transform;
  import hvt_pkg::*;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } point_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        w_zero;
    logic        saturated;
  } proj_t;

  localparam int DEPTH     = QUO_W + 5;
  localparam int WATCHDOG  = 4000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  hvt_in_if  in_ch ();
  hvt_out_if out_ch ();
  hvt_cfg_if cfg_ch ();

  homogeneous_vertex_transform i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source),
    .cfg_ch(cfg_ch.sink)
  );

  always #5 clk = ~clk;

  logic [63:0] matrix_regs [NUM_REGS];
  point_t      point_queue[$];
  proj_t       proj_queue[$];
  int          mismatches = 0;
  int          points_sent = 0;
  int          words_seen = 0;
  int          wzero_seen = 0;
  int          sat_seen = 0;
  int          idle_cycles = 0;
  bit          in_took = 0;
  bit          out_took = 0;

  function automatic logic signed [SUM_W-1:0] row_total(int r, point_t p);
    logic signed [63:0] m0, m1, m2, m3;
    logic signed [SUM_W-1:0] s;
    m0 = $signed(matrix_regs[2*r][31:0]);
    m1 = $signed(matrix_regs[2*r][63:32]);
    m2 = $signed(matrix_regs[2*r+1][31:0]);
    m3 = $signed(matrix_regs[2*r+1][63:32]);
    s = SUM_W'(m0 * $signed(p.x)) + SUM_W'(m1 * $signed(p.y))
      + SUM_W'(m2 * $signed(p.z)) + SUM_W'(m3 * 64'sd65536);
    return s;
  endfunction

  function automatic logic [31:0] clamp_div(logic signed [SUM_W-1:0] num,
                                            logic signed [SUM_W-1:0] den, ref bit sat);
    logic signed [127:0] n, d, q;
    n = 128'(num) <<< FRAC_BITS_DEF;
    d = 128'(den);
    q = n / d;
    if (q > 128'sh7FFFFFFF) begin
      sat = 1;
      return 32'h7FFFFFFF;
    end
    if (q < -128'sh80000000) begin
      sat = 1;
      return 32'h80000000;
    end
    return q[31:0];
  endfunction

  function automatic proj_t project_point(point_t p);
    proj_t r;
    bit sat;
    logic signed [SUM_W-1:0] w;
    sat = 0;
    w = row_total(3, p);
    r = '0;
    if (w == 0) begin
      r.w_zero = 1'b1;
      return r;
    end
    r.x = clamp_div(row_total(0, p), w, sat);
    r.y = clamp_div(row_total(1, p), w, sat);
    r.z = clamp_div(row_total(2, p), w, sat);
    r.saturated = sat;
    return r;
  endfunction

  always @(posedge clk) begin
    in_took  <= in_ch.valid && in_ch.ready;
    out_took <= out_ch.valid && out_ch.ready;
  end

  int in_wait = 0;
  always @(negedge clk) begin
    if (in_took) begin
      in_wait = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
    end
    if (in_took || !in_ch.valid) begin
      if (in_wait > 0) begin
        in_wait--;
        in_ch.valid <= 1'b0;
      end else if (point_queue.size() > 0) begin
        in_ch.valid <= 1'b1;
        in_ch.in_x  <= point_queue[0].x;
        in_ch.in_y  <= point_queue[0].y;
        in_ch.in_z  <= point_queue[0].z;
        proj_queue.push_back(project_point(point_queue[0]));
        void'(point_queue.pop_front());
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  int out_wait = 0;
  always @(negedge clk) begin
    if (out_took) begin
      out_wait = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
      out_ch.ready <= (out_wait == 0);
    end else if (out_wait > 0) begin
      out_wait--;
      out_ch.ready <= (out_wait == 0);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
          || (cfg_ch.valid && cfg_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (in_ch.valid && in_ch.ready)
        points_sent <= points_sent + 1;
      if (out_ch.valid && out_ch.ready) begin
        proj_t got, want;
        got = '{out_ch.out_x, out_ch.out_y, out_ch.out_z, out_ch.w_zero, out_ch.saturated};
        words_seen <= words_seen + 1;
        if (got.w_zero) wzero_seen <= wzero_seen + 1;
        if (got.saturated) sat_seen <= sat_seen + 1;
        if (proj_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected word %h", got);
        end else begin
          want = proj_queue.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: expected x=%h y=%h z=%h wz=%b sat=%b,",
                        " got x=%h y=%h z=%h wz=%b sat=%b"},
                       want.x, want.y, want.z, want.w_zero, want.saturated,
                       got.x, got.y, got.z, got.w_zero, got.saturated);
          end
        end
      end
      if (idle_cycles >= WATCHDOG) begin
        $display("timeout with %0d words outstanding", proj_queue.size());
        $display("tb_homogeneous_vertex_transform: FAIL");
        $finish;
      end
    end
  end

  task automatic write_reg(int idx, logic [63:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx[CFG_IDX_W-1:0];
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (idx < NUM_REGS) matrix_regs[idx] = value;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    while (point_queue.size() > 0 || in_ch.valid || proj_queue.size() > 0)
      @(posedge clk);
    repeat (DEPTH + 4) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return $urandom_range(0, 1) ? 32'h00010000 : 32'hFFFF0000;
      3: return $urandom;
      default: return 32'($signed($urandom_range(0, 32'h00FFFFFF)) - 32'sh00800000);
    endcase
  endfunction

  function automatic logic [63:0] rand_pair(bit keep_small);
    logic [31:0] a, b;
    if (keep_small) begin
      a = 32'($signed($urandom_range(0, 32'h0003FFFF)) - 32'sh00020000);
      b = 32'($signed($urandom_range(0, 32'h0003FFFF)) - 32'sh00020000);
    end else begin
      a = rand_coord();
      b = rand_coord();
    end
    return {b, a};
  endfunction

  task automatic queue_points(int n);
    point_t p;
    for (int i = 0; i < n; i++) begin
      p.x = rand_coord();
      p.y = rand_coord();
      p.z = rand_coord();
      point_queue.push_back(p);
    end
  endtask

  initial begin
    point_t p;
    logic [31:0] edges [5];
    edges = '{32'h0, 32'h7FFFFFFF, 32'h80000000, 32'h00010000, 32'hFFFFFFFF};
    in_ch.valid = 1'b0;
    in_ch.in_x = '0;
    in_ch.in_y = '0;
    in_ch.in_z = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    matrix_regs[REG_R0_C01] = 64'h0000_0000_0001_0000;
    matrix_regs[REG_R0_C23] = 64'h0;
    matrix_regs[REG_R1_C01] = 64'h0001_0000_0000_0000;
    matrix_regs[REG_R1_C23] = 64'h0;
    matrix_regs[REG_R2_C01] = 64'h0;
    matrix_regs[REG_R2_C23] = 64'h0000_0000_0001_0000;
    matrix_regs[REG_R3_C01] = 64'h0;
    matrix_regs[REG_R3_C23] = 64'h0001_0000_0000_0000;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < 5; i++) begin
      p.x = edges[i];
      p.y = edges[(i + 1) % 5];
      p.z = edges[(i + 2) % 5];
      point_queue.push_back(p);
    end
    drain();

    // Perspective matrix: w' = z, so z = 0 gives a zero w and tiny z saturates.
    write_reg(REG_R3_C01, 64'h0);
    write_reg(REG_R3_C23, 64'h0000_0000_0001_0000);
    write_reg(REG_R0_C23, 64'h0);
    write_reg(8, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(15, 64'h1234_5678_9ABC_DEF0);
    foreach (edges[i]) begin
      p.x = edges[i];
      p.y = edges[4 - i];
      p.z = 32'h0;
      point_queue.push_back(p);
      p.z = 32'h1;
      point_queue.push_back(p);
      p.z = 32'hFFFFFFFF;
      point_queue.push_back(p);
      p.z = edges[i];
      point_queue.push_back(p);
    end
    drain();

    for (int phase = 0; phase < 12; phase++) begin
      for (int r = 0; r < NUM_REGS; r++) begin
        logic [63:0] v;
        case (phase % 4)
          0: v = rand_pair(1);
          1: v = rand_pair(0);
          2: v = (phase & 4) ? 64'h8000_0000_8000_0000 : 64'h7FFF_FFFF_7FFF_FFFF;
          default: v = (r == REG_R3_C23) ? {rand_coord(), 32'h0} : rand_pair(1);
        endcase
        if (phase % 4 == 3 && r == REG_R3_C01) v = 64'h0;
        if (phase % 4 == 3 && r == REG_R2_C23) v = {32'h0, rand_coord()};
        write_reg(r, v);
      end
      queue_points(125);
      drain();
    end

    $display("covered %0d points, %0d results: %0d with zero w, %0d saturated",
             points_sent, words_seen, wzero_seen, sat_seen);
    if (mismatches == 0 && proj_queue.size() == 0)
      $display("tb_homogeneous_vertex_transform: PASS");
    else
      $display("tb_homogeneous_vertex_transform: FAIL");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/hvt_pkg.sv
rtl/hvt_in_if.sv
rtl/hvt_out_if.sv
rtl/hvt_cfg_if.sv
rtl/hvt_divider.sv
rtl/homogeneous_vertex_transform.sv
bench/tb_homogeneous_vertex_transform.sv
